@@ hdl/bsct_pkg.sv @@
// package for the button-set countdown timer
// types, register indexes and limits shared by the interfaces and modules
// no dependencies
package bsct_pkg;

    localparam int unsigned MIN_W     = 6;
    localparam int unsigned SEC_W     = 6;
    localparam int unsigned HOLD_W    = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 6;

    localparam logic [SEC_W-1:0]  SEC_TOP  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_TOP  = 6'd59;
    localparam logic [HOLD_W-1:0] HOLD_TOP = 4'd15;

    localparam logic [HOLD_W-1:0] LONG_PRESS_RST  = 4'd3;
    localparam logic [MIN_W-1:0]  MAX_MINUTES_RST = 6'd59;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MINUTES = 1'd1;

    typedef struct packed {
        logic button_one;
        logic button_two;
        logic button_three;
    } t_buttons;

    typedef struct packed {
        logic [HOLD_W-1:0] long_press_ticks;
        logic [MIN_W-1:0]  max_minutes;
    } t_cfg;

    typedef struct packed {
        logic [MIN_W-1:0]  minute_count;
        logic [SEC_W-1:0]  second_count;
        logic              run_flag;
        logic              led_state;
        logic [HOLD_W-1:0] hold_ticks;
        logic              hold_seen;
    } t_state;

    typedef struct packed {
        logic [MIN_W-1:0] minutes_left;
        logic [SEC_W-1:0] seconds_left;
        logic             running;
        logic             led_level;
        logic             alarm_pulse;
        logic             display_changed;
    } t_result;

endpackage

@@ hdl/bsct_if.sv @@
// valid/ready channel interfaces for the countdown timer
// button item in, display/status item out; depends on bsct_pkg
interface bsct_in_if;
    logic valid;
    logic ready;
    logic button_one;
    logic button_two;
    logic button_three;

    modport source (output valid, output button_one, output button_two,
                    output button_three, input ready);
    modport sink   (input valid, input button_one, input button_two,
                    input button_three, output ready);
endinterface

interface bsct_out_if;
    logic                       valid;
    logic                       ready;
    logic [bsct_pkg::MIN_W-1:0] minutes_left;
    logic [bsct_pkg::SEC_W-1:0] seconds_left;
    logic                       running;
    logic                       led_level;
    logic                       alarm_pulse;
    logic                       display_changed;

    modport source (output valid, output minutes_left, output seconds_left,
                    output running, output led_level, output alarm_pulse,
                    output display_changed, input ready);
    modport sink   (input valid, input minutes_left, input seconds_left,
                    input running, input led_level, input alarm_pulse,
                    input display_changed, output ready);
endinterface

@@ hdl/button_set_countdown_timer.sv @@
// top level of the button-set countdown timer
// config registers, timer state and result register; uses bsct_step,
// bsct_in_if, bsct_out_if and bsct_pkg
//
//   port         dir   kind          carries
//   i_item       in    valid/ready   one tick item: three button levels
//   o_item       out   valid/ready   time, run, led, alarm, changed flags
//   i_cfg_*      in    write port    long_press_ticks (0), max_minutes (1)
//
// one item per cycle while the result register is empty or being taken: the
// state update is one combinational pass from the state registers into the result register, written at accept.
// the result is valid in the cycle after accept.
// i_item.ready is high while the result register is empty or being taken.
// synchronous active-low reset clears state and the result valid and loads the config reset values.
module button_set_countdown_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bsct_in_if.sink                        i_item,
    bsct_out_if.source                     o_item,
    input  logic                           i_cfg_we,
    input  logic [bsct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsct_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import bsct_pkg::*;

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    t_result  r_result;
    t_result  n_result;
    t_buttons buttons;
    logic     r_out_valid;
    logic     accept;

    assign buttons.button_one   = i_item.button_one;
    assign buttons.button_two   = i_item.button_two;
    assign buttons.button_three = i_item.button_three;

    assign i_item.ready = ~r_out_valid | o_item.ready;
    assign accept       = i_item.valid & i_item.ready;

    bsct_step u_step (
        .i_buttons (buttons),
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks <= LONG_PRESS_RST;
            r_cfg.max_minutes      <= MAX_MINUTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LONG_PRESS:  r_cfg.long_press_ticks <= i_cfg_data[HOLD_W-1:0];
                REG_MAX_MINUTES: r_cfg.max_minutes      <= i_cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_item.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_item.valid           = r_out_valid;
    assign o_item.minutes_left    = r_result.minutes_left;
    assign o_item.seconds_left    = r_result.seconds_left;
    assign o_item.running         = r_result.running;
    assign o_item.led_level       = r_result.led_level;
    assign o_item.alarm_pulse     = r_result.alarm_pulse;
    assign o_item.display_changed = r_result.display_changed;

endmodule

@@ hdl/bsct_step.sv @@
// one-tick update of the countdown timer state
// purely combinational: buttons, config and state in, next state and result out
// depends on bsct_pkg
module bsct_step (
    input  bsct_pkg::t_buttons i_buttons,
    input  bsct_pkg::t_cfg     i_cfg,
    input  bsct_pkg::t_state   i_state,
    output bsct_pkg::t_state   o_state,
    output bsct_pkg::t_result  o_result
);
    import bsct_pkg::*;

    logic             only1;
    logic             only2;
    logic             only3;
    logic             none;
    logic             released;
    logic             alarm;
    logic             changed;
    logic [MIN_W-1:0] limit;
    t_state           s;

    assign only1 = i_buttons.button_one & ~i_buttons.button_two & ~i_buttons.button_three;
    assign only2 = i_buttons.button_two & ~i_buttons.button_one & ~i_buttons.button_three;
    assign only3 = i_buttons.button_three & ~i_buttons.button_one & ~i_buttons.button_two;
    assign none  = ~i_buttons.button_one & ~i_buttons.button_two & ~i_buttons.button_three;
    assign limit = (i_cfg.max_minutes > MIN_TOP) ? MIN_TOP : i_cfg.max_minutes;

    always_comb begin
        s        = i_state;
        released = 1'b0;
        alarm    = 1'b0;
        changed  = 1'b0;

        if (only3) begin
            s.hold_seen = 1'b1;
            if (s.hold_ticks < HOLD_TOP) begin
                s.hold_ticks = s.hold_ticks + 4'd1;
            end
        end else if (s.hold_seen) begin
            released = 1'b1;
            if (s.hold_ticks >= i_cfg.long_press_ticks) begin
                s.run_flag     = 1'b0;
                s.minute_count = '0;
                s.second_count = '0;
                changed        = 1'b1;
            end else begin
                s.run_flag = ~s.run_flag;
            end
            s.hold_seen  = 1'b0;
            s.hold_ticks = '0;
        end

        if (only1) begin
            s.run_flag = 1'b0;
            if (s.minute_count < limit) begin
                s.minute_count = s.minute_count + 6'd1;
                changed        = 1'b1;
            end
        end else if (only2) begin
            s.run_flag = 1'b0;
            if (s.second_count < SEC_TOP) begin
                s.second_count = s.second_count + 6'd1;
                changed        = 1'b1;
            end
        end else if (none && !released && s.run_flag) begin
            if (s.minute_count == '0 && s.second_count == '0) begin
                alarm       = 1'b1;
                s.run_flag  = 1'b0;
                s.led_state = 1'b1;
            end else begin
                if (s.second_count == '0) begin
                    s.minute_count = s.minute_count - 6'd1;
                    s.second_count = SEC_TOP;
                end else begin
                    s.second_count = s.second_count - 6'd1;
                end
                changed     = 1'b1;
                s.led_state = ~s.led_state;
            end
        end

        o_state                  = s;
        o_result.minutes_left    = s.minute_count;
        o_result.seconds_left    = s.second_count;
        o_result.running         = s.run_flag;
        o_result.led_level       = s.led_state;
        o_result.alarm_pulse     = alarm;
        o_result.display_changed = changed;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for button_set_countdown_timer: drives tick items with random gaps,
// predicts each result in a scoreboard class and checks it against the output item
// depends on bsct_pkg, bsct_in_if, bsct_out_if and the timer rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsct_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;

    localparam t_buttons BTN_NONE = 3'b000;
    localparam t_buttons BTN_MIN  = 3'b100;
    localparam t_buttons BTN_SEC  = 3'b010;
    localparam t_buttons BTN_RUN  = 3'b001;

    class timer_scoreboard;
        logic [HOLD_W-1:0] long_press;
        logic [MIN_W-1:0]  max_min;
        t_state            st;
        t_result           display_q[$];
        int unsigned       mismatches;

        function new();
            long_press = LONG_PRESS_RST;
            max_min    = MAX_MINUTES_RST;
            st         = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_LONG_PRESS) begin
                long_press = data[HOLD_W-1:0];
            end else if (idx == REG_MAX_MINUTES) begin
                max_min = data[MIN_W-1:0];
            end
        endfunction

        function int pending();
            return display_q.size();
        endfunction

        // one tick of the timer, result pushed for the output side
        function void note_tick(t_buttons b);
            logic             only1, only2, only3, no_btn, released;
            logic [MIN_W-1:0] limit;
            t_result          want;
            only1    = b.button_one & ~b.button_two & ~b.button_three;
            only2    = b.button_two & ~b.button_one & ~b.button_three;
            only3    = b.button_three & ~b.button_one & ~b.button_two;
            no_btn   = ~b.button_one & ~b.button_two & ~b.button_three;
            released = 1'b0;
            want     = '0;
            limit    = (max_min > MIN_TOP) ? MIN_TOP : max_min;

            if (only3) begin
                st.hold_seen = 1'b1;
                if (st.hold_ticks < HOLD_TOP) begin
                    st.hold_ticks = st.hold_ticks + 1'b1;
                end
            end else if (st.hold_seen) begin
                released = 1'b1;
                if (st.hold_ticks >= long_press) begin
                    st.run_flag     = 1'b0;
                    st.minute_count = '0;
                    st.second_count = '0;
                    want.display_changed = 1'b1;
                end else begin
                    st.run_flag = ~st.run_flag;
                end
                st.hold_seen  = 1'b0;
                st.hold_ticks = '0;
            end

            if (only1) begin
                st.run_flag = 1'b0;
                if (st.minute_count < limit) begin
                    st.minute_count = st.minute_count + 1'b1;
                    want.display_changed = 1'b1;
                end
            end else if (only2) begin
                st.run_flag = 1'b0;
                if (st.second_count < SEC_TOP) begin
                    st.second_count = st.second_count + 1'b1;
                    want.display_changed = 1'b1;
                end
            end else if (no_btn && !released && st.run_flag) begin
                if (st.minute_count == '0 && st.second_count == '0) begin
                    want.alarm_pulse = 1'b1;
                    st.run_flag      = 1'b0;
                    st.led_state     = 1'b1;
                end else begin
                    if (st.second_count == '0) begin
                        st.minute_count = st.minute_count - 1'b1;
                        st.second_count = SEC_TOP;
                    end else begin
                        st.second_count = st.second_count - 1'b1;
                    end
                    want.display_changed = 1'b1;
                    st.led_state = ~st.led_state;
                end
            end

            want.minutes_left = st.minute_count;
            want.seconds_left = st.second_count;
            want.running      = st.run_flag;
            want.led_level    = st.led_state;
            display_q.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            logic    bad;
            if (display_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %0d:%0d run %0b led %0b alarm %0b chg %0b",
                             got.minutes_left, got.seconds_left, got.running,
                             got.led_level, got.alarm_pulse, got.display_changed);
                end
                return;
            end
            want = display_q.pop_front();
            bad = (got.minutes_left !== want.minutes_left)
                || (got.seconds_left !== want.seconds_left)
                || (got.running !== want.running)
                || (got.led_level !== want.led_level)
                || (got.alarm_pulse !== want.alarm_pulse)
                || (got.display_changed !== want.display_changed);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: expected %0d:%0d run %0b led %0b alarm %0b chg %0b",
                             $realtime, want.minutes_left, want.seconds_left, want.running,
                             want.led_level, want.alarm_pulse, want.display_changed);
                    $display("                 got      %0d:%0d run %0b led %0b alarm %0b chg %0b",
                             got.minutes_left, got.seconds_left, got.running,
                             got.led_level, got.alarm_pulse, got.display_changed);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    bsct_in_if  in_ch ();
    bsct_out_if out_ch ();

    button_set_countdown_timer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_ch),
        .o_item      (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    timer_scoreboard sb = new();

    logic        src_idle_on = 1'b1;
    logic        snk_idle_on = 1'b1;
    logic        long_hold   = 1'b0;
    int unsigned ticks_sent  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        t_result  got;
        t_buttons btn;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.minutes_left    = out_ch.minutes_left;
                got.seconds_left    = out_ch.seconds_left;
                got.running         = out_ch.running;
                got.led_level       = out_ch.led_level;
                got.alarm_pulse     = out_ch.alarm_pulse;
                got.display_changed = out_ch.display_changed;
                sb.check_result(got);
            end
            if (in_ch.valid && in_ch.ready) begin
                btn.button_one   = in_ch.button_one;
                btn.button_two   = in_ch.button_two;
                btn.button_three = in_ch.button_three;
                sb.note_tick(btn);
            end
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic send_tick(input t_buttons b);
        @(negedge i_clk);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.button_one   <= b.button_one;
        in_ch.button_two   <= b.button_two;
        in_ch.button_three <= b.button_three;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        ticks_sent++;
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [HOLD_W-1:0] lp, input logic [MIN_W-1:0] mm);
        stop_items();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        write_reg(REG_LONG_PRESS, CFG_DAT_W'(lp));
        write_reg(REG_MAX_MINUTES, mm);
    endtask

    task automatic random_release();
        t_buttons rel;
        do rel = 3'($urandom_range(0, 7)); while (rel == BTN_RUN);
        send_tick(rel);
    endtask

    task automatic random_sequence();
        int unsigned kind;
        int unsigned n;
        int unsigned lp;
        t_buttons    rnd;
        lp   = sb.long_press;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                rnd = 3'($urandom_range(0, 7));
                send_tick(rnd);
            end
            2, 3, 4, 5, 6: begin
                // set a time, press run for n ticks, then send mostly idle ticks
                repeat ($urandom_range(0, 2)) send_tick(BTN_MIN);
                repeat ($urandom_range(0, 6)) send_tick(BTN_SEC);
                n = (lp > 1) ? $urandom_range(1, lp - 1) : 1;
                repeat (n) send_tick(BTN_RUN);
                send_tick(BTN_NONE);
                repeat ($urandom_range(0, 12)) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_tick(BTN_RUN);
                    end else begin
                        send_tick(BTN_NONE);
                    end
                end
            end
            7: begin
                n = lp + $urandom_range(0, 3);
                if (n == 0) n = 1;
                repeat (n) send_tick(BTN_RUN);
                random_release();
            end
            8: begin
                do rnd = 3'($urandom_range(3, 7)); while (rnd == BTN_MIN);
                send_tick(rnd);
            end
            default: begin
                repeat ($urandom_range(1, 4)) send_tick(BTN_RUN);
                random_release();
            end
        endcase
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = ticks_sent + count;
        while (ticks_sent < target) random_sequence();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.button_one   = 1'b0;
        in_ch.button_two   = 1'b0;
        in_ch.button_three = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks under reset settings
        send_tick(BTN_NONE);
        send_tick(BTN_SEC);
        send_tick(BTN_RUN);
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);
        send_tick(BTN_MIN);
        send_tick(BTN_RUN);
        send_tick(BTN_MIN);
        repeat (3) send_tick(BTN_RUN);
        send_tick(BTN_NONE);
        send_tick(BTN_MIN);
        send_tick(BTN_RUN);
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);
        send_tick(BTN_SEC);
        send_tick(BTN_MIN | BTN_SEC);
        send_tick(BTN_MIN | BTN_SEC | BTN_RUN);
        send_tick(BTN_MIN | BTN_RUN);
        send_tick(BTN_SEC | BTN_RUN);

        set_config(4'd1, 6'd1);
        long_hold = 1'b1;
        run_random(110);
        set_config(4'd15, 6'd59);
        run_random(130);
        set_config(4'd0, 6'd0);
        run_random(100);
        set_config(4'd8, 6'd63);
        run_random(120);
        set_config(4'd4, 6'd30);
        run_random(130);
        set_config(4'd3, 6'd59);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        run_random(140);

        stop_items();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bsct_pkg.sv
hdl/bsct_if.sv
hdl/bsct_step.sv
hdl/button_set_countdown_timer.sv
tb/sv/tb_top.sv
